/* rtl/gcef_pkg.sv */
// Shared constants, types and table builders for the Gaussian-charge Coulomb block.
package gcef_pkg;

    // Table size: points are spaced 8/ERF_TABLE_ENTRIES apart over [0, 8].
    localparam int ERF_TABLE_ENTRIES = 1024;
    localparam int ROM_DEPTH         = ERF_TABLE_ENTRIES + 1;
    localparam int ROM_AW            = $clog2(ROM_DEPTH);
    localparam int TAB_SQ            = ERF_TABLE_ENTRIES * ERF_TABLE_ENTRIES;
    localparam int SIMPSON_DIV       = 3 * ERF_TABLE_ENTRIES;

    // Field widths of the input and result words.
    localparam int DIST_W    = 24;
    localparam int ZETA_W    = 24;
    localparam int POT_W     = 32;
    localparam int SLOPE_W   = 33;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;
    localparam int PAD_W     = M_TDATA_W - POT_W - SLOPE_W;

    // Step counts of the iterative units.
    localparam int ISQ_STEPS  = 32;
    localparam int ZDIV_STEPS = 32;
    localparam int QDIV_STEPS = 49;

    // Fixed-point constants in Q.60.
    localparam logic [63:0] ONE_Q60             = 64'h1000_0000_0000_0000;
    localparam logic [63:0] TWO_OVER_ROOTPI_Q60 = 64'd1300932607094740443;

    // Table types.
    typedef logic [32:0] t_erf_rom [ROM_DEPTH];
    typedef logic [30:0] t_hgt_rom [ROM_DEPTH];

    // Values that ride along the square-root and width-division stages.
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [31:0]       zone;
        logic              one_zero;
        logic              pc;
    } t_side;

    // Product of two Q.60 values, floored back to Q.60.
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // exp(-f) for f in [0, 1] by an alternating Taylor series.
    function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
        logic [63:0] plus;
        logic [63:0] minus;
        logic [63:0] term;
        logic        done;
        plus  = ONE_Q60;
        minus = '0;
        term  = ONE_Q60;
        done  = 1'b0;
        for (int i = 1; i < 40; i++) begin
            if (!done) begin
                term = mul_q60(term, f) / 64'(i);
                if (term == '0) begin
                    done = 1'b1;
                end else if ((i & 1) != 0) begin
                    minus = minus + term;
                end else begin
                    plus = plus + term;
                end
            end
        end
        return plus - minus;
    endfunction

    // exp(-x^2) at x = 4*j/ERF_TABLE_ENTRIES, integer part of x^2 by powers of exp(-1).
    function automatic logic [63:0] gauss_at(input logic [63:0] j, input logic [63:0] einv);
        logic [63:0] t;
        logic [63:0] ip;
        logic [63:0] rem;
        logic [63:0] q;
        logic [63:0] r2;
        logic [63:0] f;
        logic [63:0] v;
        t   = 64'd16 * j * j;
        ip  = t / 64'(TAB_SQ);
        rem = t % 64'(TAB_SQ);
        q   = (rem << 30) / 64'(TAB_SQ);
        r2  = (rem << 30) % 64'(TAB_SQ);
        f   = (q << 30) + ((r2 << 30) / 64'(TAB_SQ));
        v   = exp_neg_frac(f);
        for (int i = 0; i < 65; i++) begin
            if ((64'(i) < ip) && (v != '0)) begin
                v = mul_q60(v, einv);
            end
        end
        return v;
    endfunction

    // erf at the table points: Simpson sum of the Gaussian, Q.32, clipped at 1.0.
    function automatic t_erf_rom build_erf_rom();
        t_erf_rom    tab;
        logic [63:0] einv;
        logic [63:0] integral;
        logic [63:0] g0;
        logic [63:0] g1;
        logic [63:0] g2;
        logic [63:0] e;
        einv     = exp_neg_frac(ONE_Q60);
        integral = '0;
        g0       = gauss_at(64'd0, einv);
        tab[0]   = '0;
        for (int k = 0; k < ERF_TABLE_ENTRIES; k++) begin
            g1 = gauss_at(64'(2 * k + 1), einv);
            g2 = gauss_at(64'(2 * k + 2), einv);
            integral = integral + ((g0 + 64'd4 * g1 + g2) / 64'(SIMPSON_DIV)) * 64'd4;
            e = (mul_q60(TWO_OVER_ROOTPI_Q60, integral) + (64'd1 << 27)) >> 28;
            if (e > (64'd1 << 32)) begin
                e = 64'd1 << 32;
            end
            tab[k + 1] = e[32:0];
            g0 = g2;
        end
        return tab;
    endfunction

    // (2/sqrt(pi))*exp(-x^2) at the table points, rounded to Q.30.
    function automatic t_hgt_rom build_hgt_rom();
        t_hgt_rom    tab;
        logic [63:0] einv;
        logic [63:0] h;
        einv = exp_neg_frac(ONE_Q60);
        for (int k = 0; k < ROM_DEPTH; k++) begin
            h = (mul_q60(TWO_OVER_ROOTPI_Q60, gauss_at(64'(2 * k), einv)) +
                 (64'd1 << 29)) >> 30;
            tab[k] = h[30:0];
        end
        return tab;
    endfunction

endpackage

/* rtl/gaussian_coulomb_energy_force.sv */
// Top level: pipelined Gaussian-charge Coulomb potential and radial slope.
//
// One word is accepted per clock while the skid register is empty, and one
// result word leaves per clock while the receiver is ready. The pipeline
// holds a 32-step bit-serial square root and a 32-step long division for
// the effective width, one table read of two neighboring points each from two
// 1025-entry ROMs with interpolation, and two chained 49-step long divisions
// by the distance (the first runs the slope term beside it). A two-entry
// output register with skid keeps the input side open while a finished word
// waits. When both widths are zero the point-charge form 1/r, -1/r^2 is used;
// at zero distance the slope is zero. Oversized results clip to all ones (the
// slope in magnitude, before negation) and raise the saturated flag in tuser.
module gaussian_coulomb_energy_force (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // distance [23:0], zeta_first [47:24], zeta_second [71:48]
    input  logic [gcef_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // potential [31:0], slope [64:32], zero fill [71:65]
    output logic [gcef_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // saturated [0]
    output logic                             m_axis_tuser
);
    import gcef_pkg::*;

    localparam int N_STAGES = 1 + (ISQ_STEPS + 1) + ZDIV_STEPS + 5 + 2 * QDIV_STEPS + 1;
    localparam int LAST     = N_STAGES - 1;
    localparam int PW       = 35 + ROM_AW;

    localparam t_erf_rom ERF_ROM = build_erf_rom();
    localparam t_hgt_rom HGT_ROM = build_hgt_rom();

    // One square-root step: try the current bit pair.
    function automatic logic [127:0] isqrt_step(input logic [63:0] v, input logic [63:0] res,
                                                input logic [63:0] bitv);
        logic [63:0] trial;
        trial = res + bitv;
        if (v >= trial) begin
            return {v - trial, (res >> 1) + bitv};
        end
        return {v, res >> 1};
    endfunction

    // One restoring division step with a 32-bit divisor.
    function automatic logic [63:0] zdiv_step(input logic [31:0] rem, input logic [31:0] nq,
                                              input logic [31:0] d);
        logic [32:0] t;
        logic        q;
        t = {rem, nq[31]};
        q = (t >= {1'b0, d});
        if (q) begin
            t = t - {1'b0, d};
        end
        return {t[31:0], nq[30:0], q};
    endfunction

    // One restoring division step by the distance.
    function automatic logic [72:0] rdiv_step(input logic [23:0] rem, input logic [48:0] nq,
                                              input logic [23:0] d);
        logic [24:0] t;
        logic        q;
        t = {rem, nq[48]};
        q = (t >= {1'b0, d});
        if (q) begin
            t = t - {1'b0, d};
        end
        return {t[23:0], nq[47:0], q};
    endfunction

    // Pipeline control.
    logic                en;
    logic [N_STAGES-1:0] r_vld;
    logic                r_out_vld;
    logic                r_skid_vld;
    logic                out_free;

    // Input stage.
    logic [DIST_W-1:0] r_in_dist;
    logic [ZETA_W-1:0] r_in_zi;
    logic [ZETA_W-1:0] r_in_zj;

    // Square-root section; index 0 holds the products.
    logic [63:0] r_isq_v   [ISQ_STEPS + 1];
    logic [63:0] r_isq_res [ISQ_STEPS + 1];
    logic [62:0] r_isq_num [ISQ_STEPS + 1];
    t_side       r_isq_side[ISQ_STEPS + 1];

    // Width division section.
    logic [31:0] r_zd_rem [ZDIV_STEPS];
    logic [31:0] r_zd_nq  [ZDIV_STEPS];
    logic [31:0] r_zd_d   [ZDIV_STEPS];
    t_side       r_zd_side[ZDIV_STEPS];

    // Argument stage.
    logic [31:0]       r_u_z;
    logic [47:0]       r_u_u;
    logic [DIST_W-1:0] r_u_dist;
    logic              r_u_pc;

    // Table read stage.
    logic [32:0]       r_rom_ea;
    logic [32:0]       r_rom_eb;
    logic [30:0]       r_rom_ha;
    logic [30:0]       r_rom_hb;
    logic [15:0]       r_rom_w;
    logic              r_rom_lim;
    logic [31:0]       r_rom_z;
    logic [DIST_W-1:0] r_rom_dist;
    logic              r_rom_pc;

    // Interpolation product stage.
    logic [48:0]       r_lm_pe;
    logic [46:0]       r_lm_ph;
    logic              r_lm_edn;
    logic              r_lm_hdn;
    logic [32:0]       r_lm_ea;
    logic [30:0]       r_lm_ha;
    logic              r_lm_lim;
    logic [31:0]       r_lm_z;
    logic [DIST_W-1:0] r_lm_dist;
    logic              r_lm_pc;

    // Interpolated values.
    logic [32:0]       r_eh_e;
    logic [30:0]       r_eh_h;
    logic [31:0]       r_eh_z;
    logic [DIST_W-1:0] r_eh_dist;

    // Width times slope value.
    logic [62:0]       r_zh_zh;
    logic [32:0]       r_zh_e;
    logic [DIST_W-1:0] r_zh_dist;

    // First division by r: (E<<16)/r and (z*H>>22)/r side by side.
    logic [23:0]       r_d1_rem [QDIV_STEPS];
    logic [48:0]       r_d1_nq  [QDIV_STEPS];
    logic [23:0]       r_d1_arem[QDIV_STEPS];
    logic [48:0]       r_d1_anq [QDIV_STEPS];
    logic [DIST_W-1:0] r_d1_dist[QDIV_STEPS];
    logic [24:0]       r_d1_pot0[QDIV_STEPS];

    // Second division by r: B = Q1/r.
    logic [23:0]       r_d2_rem [QDIV_STEPS];
    logic [48:0]       r_d2_nq  [QDIV_STEPS];
    logic [32:0]       r_d2_q1hi[QDIV_STEPS];
    logic [40:0]       r_d2_a   [QDIV_STEPS];
    logic [DIST_W-1:0] r_d2_dist[QDIV_STEPS];
    logic [24:0]       r_d2_pot0[QDIV_STEPS];

    // Final and output words.
    logic [POT_W-1:0]   r_fin_pot;
    logic [SLOPE_W-1:0] r_fin_slope;
    logic               r_fin_sat;
    logic [POT_W-1:0]   r_out_pot;
    logic [SLOPE_W-1:0] r_out_slope;
    logic               r_out_sat;
    logic [POT_W-1:0]   r_skid_pot;
    logic [SLOPE_W-1:0] r_skid_slope;
    logic               r_skid_sat;

    // Combinational values between stages.
    logic [47:0]        sq_ij;
    logic [47:0]        sq_ii;
    logic [47:0]        sq_jj;
    logic [48:0]        sq_sum;
    t_side              sq_side;
    logic [31:0]        u_z;
    logic [55:0]        u_prod;
    logic [PW-1:0]      rom_pos;
    logic [ROM_AW-1:0]  rom_k;
    logic [ROM_AW-1:0]  rom_k1;
    logic [32:0]        lm_de;
    logic [30:0]        lm_dh;
    logic               lm_edn;
    logic               lm_hdn;
    logic [32:0]        eh_e;
    logic [30:0]        eh_h;
    logic [48:0]        fin_b;
    logic [48:0]        fin_a;
    logic [48:0]        fin_mag;
    logic [32:0]        fin_pot;
    logic [POT_W-1:0]   fin_magc;

    // The pipeline moves as a whole unless the skid register is occupied.
    assign en            = ~r_skid_vld;
    assign s_axis_tready = en;
    assign out_free      = ~r_out_vld | m_axis_tready;

    // Products for the effective width.
    assign sq_ij  = r_in_zi * r_in_zj;
    assign sq_ii  = r_in_zi * r_in_zi;
    assign sq_jj  = r_in_zj * r_in_zj;
    assign sq_sum = {1'b0, sq_ii} + {1'b0, sq_jj};

    always_comb begin
        sq_side.distance = r_in_dist;
        sq_side.zone     = (r_in_zi == '0) ? {r_in_zj, 8'd0} : {r_in_zi, 8'd0};
        sq_side.one_zero = (r_in_zi == '0) | (r_in_zj == '0);
        sq_side.pc       = (r_in_zi == '0) & (r_in_zj == '0);
    end

    // Effective width and the scaled argument z*r.
    assign u_z    = r_zd_side[ZDIV_STEPS-1].one_zero ? r_zd_side[ZDIV_STEPS-1].zone
                                                     : r_zd_nq[ZDIV_STEPS-1];
    assign u_prod = u_z * r_zd_side[ZDIV_STEPS-1].distance;

    // Table position from the argument.
    assign rom_pos = PW'(r_u_u[34:0]) * PW'(ERF_TABLE_ENTRIES);
    assign rom_k   = rom_pos[34 + ROM_AW:35];
    assign rom_k1  = rom_k + ROM_AW'(1);

    // Interpolation differences.
    always_comb begin
        lm_edn = r_rom_eb < r_rom_ea;
        lm_hdn = r_rom_hb < r_rom_ha;
        lm_de  = lm_edn ? (r_rom_ea - r_rom_eb) : (r_rom_eb - r_rom_ea);
        lm_dh  = lm_hdn ? (r_rom_ha - r_rom_hb) : (r_rom_hb - r_rom_ha);
    end

    // Interpolated erf and slope value, with the point-charge and far-range cases.
    always_comb begin
        eh_e = r_lm_edn ? (r_lm_ea - r_lm_pe[48:16]) : (r_lm_ea + r_lm_pe[48:16]);
        eh_h = r_lm_hdn ? (r_lm_ha - r_lm_ph[46:16]) : (r_lm_ha + r_lm_ph[46:16]);
        if (r_lm_pc | r_lm_lim) begin
            eh_e = 33'h1_0000_0000;
        end
        if (r_lm_lim) begin
            eh_h = '0;
        end
    end

    // Final combination and clipping.
    always_comb begin
        fin_b   = r_d2_nq[QDIV_STEPS-1];
        fin_a   = {8'd0, r_d2_a[QDIV_STEPS-1]};
        fin_pot = r_d2_q1hi[QDIV_STEPS-1];
        fin_mag = (fin_b > fin_a) ? (fin_b - fin_a) : '0;
        if (r_d2_dist[QDIV_STEPS-1] == '0) begin
            fin_pot = {8'd0, r_d2_pot0[QDIV_STEPS-1]};
            fin_mag = '0;
        end
        fin_magc = (fin_mag[48:32] != '0) ? '1 : fin_mag[31:0];
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[N_STAGES-2:0], s_axis_tvalid};
        end
    end

    // Datapath registers, all advancing together.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_dist <= s_axis_tdata[DIST_W-1:0];
            r_in_zi   <= s_axis_tdata[DIST_W + ZETA_W - 1:DIST_W];
            r_in_zj   <= s_axis_tdata[DIST_W + 2 * ZETA_W - 1:DIST_W + ZETA_W];

            r_isq_v[0]    <= {1'b0, sq_sum, 14'd0};
            r_isq_res[0]  <= '0;
            r_isq_num[0]  <= {sq_ij, 15'd0};
            r_isq_side[0] <= sq_side;
            for (int i = 0; i < ISQ_STEPS; i++) begin
                {r_isq_v[i + 1], r_isq_res[i + 1]} <=
                    isqrt_step(r_isq_v[i], r_isq_res[i], 64'd1 << (62 - 2 * i));
                r_isq_num[i + 1]  <= r_isq_num[i];
                r_isq_side[i + 1] <= r_isq_side[i];
            end

            {r_zd_rem[0], r_zd_nq[0]} <= zdiv_step({1'b0, r_isq_num[ISQ_STEPS][62:32]},
                                                   r_isq_num[ISQ_STEPS][31:0],
                                                   r_isq_res[ISQ_STEPS][31:0]);
            r_zd_d[0]    <= r_isq_res[ISQ_STEPS][31:0];
            r_zd_side[0] <= r_isq_side[ISQ_STEPS];
            for (int s = 1; s < ZDIV_STEPS; s++) begin
                {r_zd_rem[s], r_zd_nq[s]} <= zdiv_step(r_zd_rem[s - 1], r_zd_nq[s - 1],
                                                       r_zd_d[s - 1]);
                r_zd_d[s]    <= r_zd_d[s - 1];
                r_zd_side[s] <= r_zd_side[s - 1];
            end

            r_u_z    <= u_z;
            r_u_u    <= u_prod[55:8];
            r_u_dist <= r_zd_side[ZDIV_STEPS-1].distance;
            r_u_pc   <= r_zd_side[ZDIV_STEPS-1].pc;

            // Synchronous ROM reads at the two neighboring points.
            r_rom_ea   <= ERF_ROM[rom_k];
            r_rom_eb   <= ERF_ROM[rom_k1];
            r_rom_ha   <= HGT_ROM[rom_k];
            r_rom_hb   <= HGT_ROM[rom_k1];
            r_rom_w    <= rom_pos[34:19];
            r_rom_lim  <= (r_u_u[47:35] != '0);
            r_rom_z    <= r_u_z;
            r_rom_dist <= r_u_dist;
            r_rom_pc   <= r_u_pc;

            r_lm_pe   <= lm_de * r_rom_w;
            r_lm_ph   <= lm_dh * r_rom_w;
            r_lm_edn  <= lm_edn;
            r_lm_hdn  <= lm_hdn;
            r_lm_ea   <= r_rom_ea;
            r_lm_ha   <= r_rom_ha;
            r_lm_lim  <= r_rom_lim;
            r_lm_z    <= r_rom_z;
            r_lm_dist <= r_rom_dist;
            r_lm_pc   <= r_rom_pc;

            r_eh_e    <= eh_e;
            r_eh_h    <= eh_h;
            r_eh_z    <= r_lm_z;
            r_eh_dist <= r_lm_dist;

            r_zh_zh   <= r_eh_z * r_eh_h;
            r_zh_e    <= r_eh_e;
            r_zh_dist <= r_eh_dist;

            {r_d1_rem[0], r_d1_nq[0]}   <= rdiv_step('0, {r_zh_e, 16'd0}, r_zh_dist);
            {r_d1_arem[0], r_d1_anq[0]} <= rdiv_step('0, {8'd0, r_zh_zh[62:22]}, r_zh_dist);
            r_d1_dist[0] <= r_zh_dist;
            r_d1_pot0[0] <= r_zh_zh[62:38];
            for (int s = 1; s < QDIV_STEPS; s++) begin
                {r_d1_rem[s], r_d1_nq[s]} <= rdiv_step(r_d1_rem[s - 1], r_d1_nq[s - 1],
                                                       r_d1_dist[s - 1]);
                {r_d1_arem[s], r_d1_anq[s]} <= rdiv_step(r_d1_arem[s - 1], r_d1_anq[s - 1],
                                                         r_d1_dist[s - 1]);
                r_d1_dist[s] <= r_d1_dist[s - 1];
                r_d1_pot0[s] <= r_d1_pot0[s - 1];
            end

            {r_d2_rem[0], r_d2_nq[0]} <= rdiv_step('0, r_d1_nq[QDIV_STEPS-1],
                                                   r_d1_dist[QDIV_STEPS-1]);
            r_d2_q1hi[0] <= r_d1_nq[QDIV_STEPS-1][48:16];
            r_d2_a[0]    <= r_d1_anq[QDIV_STEPS-1][40:0];
            r_d2_dist[0] <= r_d1_dist[QDIV_STEPS-1];
            r_d2_pot0[0] <= r_d1_pot0[QDIV_STEPS-1];
            for (int s = 1; s < QDIV_STEPS; s++) begin
                {r_d2_rem[s], r_d2_nq[s]} <= rdiv_step(r_d2_rem[s - 1], r_d2_nq[s - 1],
                                                       r_d2_dist[s - 1]);
                r_d2_q1hi[s] <= r_d2_q1hi[s - 1];
                r_d2_a[s]    <= r_d2_a[s - 1];
                r_d2_dist[s] <= r_d2_dist[s - 1];
                r_d2_pot0[s] <= r_d2_pot0[s - 1];
            end

            r_fin_pot   <= fin_pot[32] ? '1 : fin_pot[31:0];
            r_fin_slope <= SLOPE_W'(0) - {1'b0, fin_magc};
            r_fin_sat   <= fin_pot[32] | (fin_mag[48:32] != '0);
        end
    end

    // Output register with skid: a word leaving the pipeline goes to the skid
    // register when the output word is still waiting.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= r_vld[LAST];
            end
        end else if (en & r_vld[LAST]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_vld) begin
                r_out_pot   <= r_skid_pot;
                r_out_slope <= r_skid_slope;
                r_out_sat   <= r_skid_sat;
            end else begin
                r_out_pot   <= r_fin_pot;
                r_out_slope <= r_fin_slope;
                r_out_sat   <= r_fin_sat;
            end
        end else if (en) begin
            r_skid_pot   <= r_fin_pot;
            r_skid_slope <= r_fin_slope;
            r_skid_sat   <= r_fin_sat;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_slope, r_out_pot};
    assign m_axis_tuser  = r_out_sat;

endmodule

/* sim/gaussian_coulomb_energy_force_test.sv */
// Self-checking testbench for the Gaussian-charge Coulomb potential and slope pipeline.
`timescale 1ns / 1ps

module gaussian_coulomb_energy_force_test;

    import gcef_pkg::*;

    localparam int          N_RANDOM   = 1380;
    localparam int          QUIET_TAIL = 150;
    localparam int          IDLE_LIMIT = 5000;
    localparam int          TAIL_WAIT  = 400;
    localparam logic [63:0] MAX32      = 64'hFFFF_FFFF;
    localparam logic [63:0] ARG_LIMIT  = 64'd8 << 32;

    // One result word as the predictor sees it.
    typedef struct packed {
        logic [POT_W-1:0]   pot;
        logic [SLOPE_W-1:0] slope;
        logic               sat;
    } t_coulomb;

    // One row of the directed stimulus; known rows carry a typed-in result.
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [ZETA_W-1:0] zi;
        logic [ZETA_W-1:0] zj;
        logic              known;
        t_coulomb          res;
    } t_stim_row;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // distance [23:0], zeta_first [47:24], zeta_second [71:48]
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // potential [31:0], slope [64:32], zero fill [71:65]
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // saturated [0]
    logic                 m_axis_tuser;

    logic [63:0] erf_pts   [ROM_DEPTH];
    logic [63:0] slope_pts [ROM_DEPTH];
    t_coulomb    coulomb_due [$];
    int          errors      = 0;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    bit          quiet       = 1'b0;

    gaussian_coulomb_energy_force u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Directed rows: extremes, each width case, zero distance, far-out arguments.
    t_stim_row dir_rows [20] = '{
        '{24'd0, 24'd0, 24'd0, 1'b1, '{32'd0, 33'd0, 1'b0}},
        '{24'd1, 24'd0, 24'd0, 1'b1, '{32'hFFFF_FFFF, 33'h1_0000_0001, 1'b1}},
        '{24'hFF_FFFF, 24'd0, 24'd0, 1'b1, '{32'd256, 33'h1_FFFF_FFFF, 1'b0}},
        '{24'h01_0000, 24'd0, 24'd0, 1'b0, '0},
        '{24'h01_0000, 24'h01_0000, 24'd0, 1'b0, '0},
        '{24'h01_0000, 24'd0, 24'h01_0000, 1'b0, '0},
        '{24'h01_0000, 24'h01_0000, 24'h01_0000, 1'b0, '0},
        '{24'd0, 24'h01_0000, 24'd0, 1'b0, '0},
        '{24'd0, 24'hFF_FFFF, 24'hFF_FFFF, 1'b0, '0},
        '{24'd0, 24'd1, 24'd1, 1'b0, '0},
        '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b0, '0},
        '{24'hFF_FFFF, 24'd1, 24'd1, 1'b0, '0},
        '{24'd1, 24'd1, 24'd0, 1'b0, '0},
        '{24'd1, 24'hFF_FFFF, 24'd0, 1'b0, '0},
        '{24'd1, 24'd0, 24'hFF_FFFF, 1'b0, '0},
        '{24'h00_0100, 24'h00_8000, 24'h00_C000, 1'b0, '0},
        '{24'h08_0000, 24'h01_0000, 24'd0, 1'b0, '0},
        '{24'h07_FF00, 24'h01_0000, 24'd0, 1'b0, '0},
        '{24'h00_0001, 24'h12_3456, 24'hAB_CDEF, 1'b0, '0},
        '{24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA, 1'b0, '0}
    };

    // Q.60 product floored back to Q.60.
    function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = {64'd0, a} * {64'd0, b};
        return 64'(wide >> 60);
    endfunction

    // exp(-f) for f in [0,1] in Q.60 from the alternating series.
    function automatic logic [63:0] exp_minus(input logic [63:0] f);
        logic [63:0] pos_sum;
        logic [63:0] neg_sum;
        logic [63:0] term;
        pos_sum = 64'd1 << 60;
        neg_sum = '0;
        term    = 64'd1 << 60;
        for (int i = 1; i < 40; i++) begin
            term = q60_product(term, f) / 64'(i);
            if (term == '0) break;
            if (i % 2 == 1) neg_sum += term;
            else pos_sum += term;
        end
        return pos_sum - neg_sum;
    endfunction

    // exp(-x^2) in Q.60 at x = 4*j/N.
    function automatic logic [63:0] gauss_pt(input logic [63:0] j, input logic [63:0] einv);
        logic [63:0] sq_n;
        logic [63:0] t;
        logic [63:0] whole;
        logic [63:0] rem;
        logic [63:0] q;
        logic [63:0] r2;
        logic [63:0] v;
        sq_n  = 64'(ERF_TABLE_ENTRIES) * 64'(ERF_TABLE_ENTRIES);
        t     = 64'd16 * j * j;
        whole = t / sq_n;
        rem   = t % sq_n;
        q     = (rem << 30) / sq_n;
        r2    = (rem << 30) % sq_n;
        v     = exp_minus((q << 30) + ((r2 << 30) / sq_n));
        for (logic [63:0] i = 0; i < whole && v != '0; i++) v = q60_product(v, einv);
        return v;
    endfunction

    // Fill the erf table by Simpson sums of the Gaussian and the slope table from the Gaussian itself.
    task automatic fill_tables();
        logic [63:0] einv;
        logic [63:0] area;
        logic [63:0] g0;
        logic [63:0] g1;
        logic [63:0] g2;
        logic [63:0] e;
        einv         = exp_minus(64'd1 << 60);
        area         = '0;
        g0           = gauss_pt(64'd0, einv);
        erf_pts[0]   = '0;
        slope_pts[0] = (q60_product(TWO_OVER_ROOTPI_Q60, g0) + (64'd1 << 29)) >> 30;
        for (int k = 0; k < ERF_TABLE_ENTRIES; k++) begin
            g1 = gauss_pt(64'(2 * k + 1), einv);
            g2 = gauss_pt(64'(2 * k + 2), einv);
            area += (g0 + 64'd4 * g1 + g2) / 64'(3 * ERF_TABLE_ENTRIES) * 64'd4;
            e = (q60_product(TWO_OVER_ROOTPI_Q60, area) + (64'd1 << 27)) >> 28;
            if (e > (64'd1 << 32)) e = 64'd1 << 32;
            erf_pts[k + 1]   = e;
            slope_pts[k + 1] = (q60_product(TWO_OVER_ROOTPI_Q60, g2) + (64'd1 << 29)) >> 30;
            g0 = g2;
        end
    endtask

    // Bitwise integer square root, floor.
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != '0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Linear blend of two neighboring points with a 16-bit weight.
    function automatic logic [63:0] blend(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] w);
        if (b >= a) return a + (((b - a) * w) >> 16);
        return a - (((a - b) * w) >> 16);
    endfunction

    // Expected potential, slope and clip flag for one pair.
    function automatic t_coulomb coulomb_predict(input logic [DIST_W-1:0] r_in,
                                                 input logic [ZETA_W-1:0] zi_in,
                                                 input logic [ZETA_W-1:0] zj_in);
        logic [63:0] r;
        logic [63:0] zi;
        logic [63:0] zj;
        logic [63:0] z;
        logic [63:0] u;
        logic [63:0] pos;
        logic [63:0] idx;
        logic [63:0] w;
        logic [63:0] e;
        logic [63:0] h;
        logic [63:0] b;
        logic [63:0] a;
        logic [63:0] pot;
        logic [63:0] mag;
        t_coulomb    res;
        r   = 64'(r_in);
        zi  = 64'(zi_in);
        zj  = 64'(zj_in);
        pot = '0;
        mag = '0;
        res = '0;
        if (zi == '0 && zj == '0) begin
            // Point charges: 1/r and -1/r^2, nothing at zero distance.
            if (r != '0) begin
                pot = (64'd1 << 32) / r;
                mag = (64'd1 << 48) / (r * r);
            end
        end else begin
            if (zi == '0) z = zj << 8;
            else if (zj == '0) z = zi << 8;
            else z = ((zi * zj) << 15) / int_sqrt((zi * zi + zj * zj) << 14);
            if (r == '0) begin
                pot = (z * slope_pts[0]) >> 38;
            end else begin
                u = (z * r) >> 8;
                if (u >= ARG_LIMIT) begin
                    // Past the table: erf is one, the Gaussian term vanishes.
                    e = 64'd1 << 32;
                    h = '0;
                end else begin
                    pos = (u * 64'(ERF_TABLE_ENTRIES)) >> 3;
                    idx = pos >> 32;
                    w   = (pos >> 16) & 64'hFFFF;
                    if (idx >= 64'(ERF_TABLE_ENTRIES)) begin
                        idx = 64'(ERF_TABLE_ENTRIES - 1);
                        w   = 64'hFFFF;
                    end
                    e = blend(erf_pts[idx], erf_pts[idx + 1], w);
                    h = blend(slope_pts[idx], slope_pts[idx + 1], w);
                end
                pot = e / r;
                b   = (e << 16) / (r * r);
                a   = (z * h) / (r << 22);
                mag = (b > a) ? b - a : '0;
            end
        end
        if (pot > MAX32) begin
            pot     = MAX32;
            res.sat = 1'b1;
        end
        if (mag > MAX32) begin
            mag     = MAX32;
            res.sat = 1'b1;
        end
        res.pot   = pot[31:0];
        res.slope = 33'(64'd0 - mag);
        return res;
    endfunction

    // A 24-bit field value: full range, near one, random length, an extreme, or a mid-range value.
    function automatic logic [23:0] pick_field();
        case ($urandom_range(0, 4))
            0:       return 24'($urandom);
            1:       return 24'($urandom_range(32'h0000_4000, 32'h0004_0000));
            2:       return 24'($urandom) >> $urandom_range(0, 23);
            3:       return ($urandom_range(0, 1) != 0) ? 24'hFF_FFFF : 24'd1;
            default: return 24'($urandom_range(32'h0000_0100, 32'h0010_0000));
        endcase
    endfunction

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver side: random stall bursts, none in the closing stretch.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left    <= $urandom_range(1, 16);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result check against the oldest expectation, plus the stall watchdog.
    always @(posedge i_clk) begin
        t_coulomb want;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (coulomb_due.size() == 0) begin
                $display("%0t: unexpected word %h", $time, m_axis_tdata);
                errors = errors + 1;
            end else begin
                want = coulomb_due.pop_front();
                if (m_axis_tdata[31:0] !== want.pot) begin
                    $display("%0t: potential expected %h actual %h", $time, want.pot,
                             m_axis_tdata[31:0]);
                    errors = errors + 1;
                end
                if (m_axis_tdata[64:32] !== want.slope) begin
                    $display("%0t: slope expected %h actual %h", $time, want.slope,
                             m_axis_tdata[64:32]);
                    errors = errors + 1;
                end
                if (m_axis_tuser !== want.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time, want.sat,
                             m_axis_tuser);
                    errors = errors + 1;
                end
            end
        end
    end

    // Sender side: directed rows, then random pairs, then the final drain.
    initial begin
        t_stim_row row;
        int        total;
        fill_tables();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        total = $size(dir_rows) + N_RANDOM;
        for (int n = 0; n < total; n++) begin
            if (n < $size(dir_rows)) begin
                row = dir_rows[n];
            end else begin
                row          = '0;
                row.distance = ($urandom_range(0, 24) == 0) ? 24'd0 : pick_field();
                row.zi       = pick_field();
                row.zj       = pick_field();
                // Point charges and single Gaussians get their share too.
                case ($urandom_range(0, 5))
                    0:       row.zi = '0;
                    1:       row.zj = '0;
                    2: begin
                        row.zi = '0;
                        row.zj = '0;
                    end
                    default: ;
                endcase
            end
            quiet = (n >= total - QUIET_TAIL);
            // Hold off once until the pipeline has fully drained.
            if (n == total / 2) begin
                s_axis_tvalid <= 1'b0;
                while (coulomb_due.size() != 0) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            s_axis_tdata  <= {row.zj, row.zi, row.distance};
            s_axis_tvalid <= 1'b1;
            do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
            coulomb_due.push_back(row.known ? row.res
                                            : coulomb_predict(row.distance, row.zi, row.zj));
        end
        s_axis_tvalid <= 1'b0;
        while (coulomb_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (errors == 0 && coulomb_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
